FILE: rtl/core/icpr_pkg.sv
// Package with constants, microcode types and the control program of the regulator core.
`default_nettype none

package icpr_pkg;

  // Fixed-point constants (period and products carry 20 fraction bits).
  localparam int unsigned FRAC_BITS = 20;
  localparam logic [16:0] INTEG_MAX = 17'd102400;
  localparam logic [16:0] DUTY_ONE = 17'd65536;
  localparam logic [16:0] DUTY_HALF = 17'd32768;
  localparam logic [11:0] LIMIT_SCALE = 12'd3600;
  localparam logic [30:0] MIN_PERIOD = 31'(64'd10 << FRAC_BITS);
  localparam logic [34:0] MIN_PRODUCT = 35'(64'd100 << FRAC_BITS);
  localparam logic [3:0] PSC_MAX = 4'd10;

  // Register indexes of the configuration port.
  localparam logic REG_GAIN = 1'b0;
  localparam logic REG_DUTY = 1'b1;

  localparam logic [15:0] GAIN_RESET = 16'd23040;
  localparam logic [16:0] DUTY_RESET = 17'd32768;

  typedef logic [3:0] step_t;

  localparam step_t STEP_IDLE = 4'd0;
  localparam step_t STEP_INTEG = 4'd1;
  localparam step_t STEP_PERIOD = 4'd2;
  localparam step_t STEP_LIMIT = 4'd3;
  localparam step_t STEP_CLAMP = 4'd4;
  localparam step_t STEP_PSC = 4'd5;
  localparam step_t STEP_TLO = 4'd6;
  localparam step_t STEP_THI = 4'd7;
  localparam step_t STEP_TON = 4'd8;
  localparam step_t STEP_OUT = 4'd9;

  typedef enum logic [3:0] {
    OP_LOAD,
    OP_INTEG,
    OP_PERIOD,
    OP_LIMIT,
    OP_CLAMP,
    OP_PSC,
    OP_TLO,
    OP_THI,
    OP_TON,
    OP_OUT
  } op_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_INPUT,
    C_PSC_MORE,
    C_OUT_BUSY
  } cond_t;

  // One control word: datapath operation, jump condition, jump target.
  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ctrl_t;

  // Control program. A taken jump goes to target, otherwise to the next step.
  function automatic ctrl_t ucode(input step_t step);
    ctrl_t w;
    case (step)
      STEP_IDLE:   w = '{op: OP_LOAD,   cond: C_NO_INPUT, target: STEP_IDLE};
      STEP_INTEG:  w = '{op: OP_INTEG,  cond: C_NEVER,    target: STEP_IDLE};
      STEP_PERIOD: w = '{op: OP_PERIOD, cond: C_NEVER,    target: STEP_IDLE};
      STEP_LIMIT:  w = '{op: OP_LIMIT,  cond: C_NEVER,    target: STEP_IDLE};
      STEP_CLAMP:  w = '{op: OP_CLAMP,  cond: C_NEVER,    target: STEP_IDLE};
      STEP_PSC:    w = '{op: OP_PSC,    cond: C_PSC_MORE, target: STEP_PSC};
      STEP_TLO:    w = '{op: OP_TLO,    cond: C_NEVER,    target: STEP_IDLE};
      STEP_THI:    w = '{op: OP_THI,    cond: C_NEVER,    target: STEP_IDLE};
      STEP_TON:    w = '{op: OP_TON,    cond: C_OUT_BUSY, target: STEP_TON};
      STEP_OUT:    w = '{op: OP_OUT,    cond: C_ALWAYS,   target: STEP_IDLE};
      default:     w = '{op: OP_LOAD,   cond: C_ALWAYS,   target: STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/integral_current_pwm_regulator_core.sv
// Top level of the integral current regulator that computes PWM timer settings.
// A new input word is accepted only in the idle step, so the core finishes one word
// before it takes the next. The prescaler search loop of the step sequencer adds
// one period per cycle, and the on-time step waits while the output register is full.
// Reset (rst_n low, synchronous) clears the integrator, empties the output
// register and loads the gain with 90.0 and the duty with one half.
`default_nettype none

module integral_current_pwm_regulator_core import icpr_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input stream.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [15:0] target_current, [31:16] measured_current
  // Result stream.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [10:0] cycle_counts, [21:11] on_counts,
                                       // [25:22] prescale, [31:26] zero
  // Configuration port.
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  // The sequencer walks a fixed program: load the word, update the
  // integrator, form the raw period, form the duty limit, clamp the period,
  // search the prescaler, form the on-time in two partial products, and
  // finally hand the result word to the output register.

  // Configuration registers.
  logic [15:0] gain_r, gain_nxt;
  logic [16:0] duty_r, duty_nxt;
  logic        cfg_wr;

  // Sequencer.
  step_t step_r, step_nxt;
  ctrl_t cw;
  logic  jump;

  // Datapath registers.
  logic signed [15:0] tgt_r, tgt_nxt;
  logic signed [15:0] meas_r, meas_nxt;
  logic [16:0] integ_r, integ_nxt;
  logic [32:0] mul_r, mul_nxt;
  logic [30:0] limit_r, limit_nxt;
  logic [16:0] dsat_r, dsat_nxt;
  logic [30:0] period_r, period_nxt;
  logic [34:0] prod_r, prod_nxt;
  logic [3:0]  psc_r, psc_nxt;
  logic [33:0] plo_r, plo_nxt;
  logic [34:0] phi_r, phi_nxt;
  logic [10:0] ton_r, ton_nxt;

  // Output register.
  logic        ovalid_r, ovalid_nxt;
  logic [10:0] ocyc_r, ocyc_nxt;
  logic [10:0] oon_r, oon_nxt;
  logic [3:0]  opsc_r, opsc_nxt;

  // Intermediate arithmetic.
  logic signed [18:0] acc;
  logic [16:0] dsat;
  logic [15:0] deff;
  logic [26:0] lim_prod;
  logic [32:0] pclip;
  logic        psc_more;
  logic [52:0] ton_sum;

  // APB side: writes take effect in the access cycle, reads are combinational.
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_comb begin
    gain_nxt = gain_r;
    duty_nxt = duty_r;
    if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_GAIN: gain_nxt = cfg_pwdata[15:0];
        REG_DUTY: duty_nxt = cfg_pwdata[16:0];
        default:  gain_nxt = gain_r;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_GAIN: cfg_prdata = {16'd0, gain_r};
      REG_DUTY: cfg_prdata = {15'd0, duty_r};
      default:  cfg_prdata = 32'd0;
    endcase
  end

  // Control word and jump decision.
  assign cw = ucode(step_r);
  assign psc_more = (prod_r < MIN_PRODUCT) && (psc_r < PSC_MAX);
  assign in_tready = (step_r == STEP_IDLE);

  always_comb begin
    case (cw.cond)
      C_NEVER:    jump = 1'b0;
      C_ALWAYS:   jump = 1'b1;
      C_NO_INPUT: jump = !in_tvalid;
      C_PSC_MORE: jump = psc_more;
      C_OUT_BUSY: jump = ovalid_r && !out_tready;
      default:    jump = 1'b0;
    endcase
    step_nxt = jump ? cw.target : step_t'(step_r + 4'd1);
  end

  // Arithmetic shared by the steps; each step uses at most one product.
  always_comb begin
    acc = $signed({2'b00, integ_r}) + 19'(tgt_r) - 19'(meas_r);
    // Duty above one saturates to one.
    dsat = (duty_r > DUTY_ONE) ? DUTY_ONE : duty_r;
    deff = (dsat > DUTY_HALF) ? 16'(DUTY_ONE - dsat) : 16'(dsat);
    lim_prod = 27'(deff * LIMIT_SCALE);
    // The upper limit is applied first, then the minimum period wins.
    pclip = (mul_r > {2'b00, limit_r}) ? {2'b00, limit_r} : mul_r;
    if (pclip < {2'b00, MIN_PERIOD}) begin
      pclip = {2'b00, MIN_PERIOD};
    end
    ton_sum = {1'b0, phi_r, 17'd0} + {19'd0, plo_r};
  end

  always_comb begin
    tgt_nxt = tgt_r;
    meas_nxt = meas_r;
    integ_nxt = integ_r;
    mul_nxt = mul_r;
    limit_nxt = limit_r;
    dsat_nxt = dsat_r;
    period_nxt = period_r;
    prod_nxt = prod_r;
    psc_nxt = psc_r;
    plo_nxt = plo_r;
    phi_nxt = phi_r;
    ton_nxt = ton_r;
    ocyc_nxt = ocyc_r;
    oon_nxt = oon_r;
    opsc_nxt = opsc_r;
    ovalid_nxt = ovalid_r && !out_tready;
    case (cw.op)
      OP_LOAD: begin
        if (in_tvalid) begin
          tgt_nxt = $signed(in_tdata[15:0]);
          meas_nxt = $signed(in_tdata[31:16]);
        end
      end
      OP_INTEG: begin
        if (acc < 0) begin
          integ_nxt = 17'd0;
        end else if (acc > $signed({2'b00, INTEG_MAX})) begin
          integ_nxt = INTEG_MAX;
        end else begin
          integ_nxt = acc[16:0];
        end
      end
      OP_PERIOD: mul_nxt = 33'(integ_r * gain_r);
      OP_LIMIT: begin
        limit_nxt = {lim_prod, 4'd0};
        dsat_nxt = dsat;
      end
      OP_CLAMP: begin
        period_nxt = pclip[30:0];
        prod_nxt = {4'd0, pclip[30:0]};
        psc_nxt = 4'd1;
      end
      OP_PSC: begin
        if (psc_more) begin
          prod_nxt = prod_r + {4'd0, period_r};
          psc_nxt = psc_r + 4'd1;
        end
      end
      OP_TLO: plo_nxt = 34'(dsat_r * prod_r[16:0]);
      OP_THI: phi_nxt = 35'(dsat_r * prod_r[34:17]);
      OP_TON: ton_nxt = ton_sum[46:36];
      OP_OUT: begin
        ovalid_nxt = 1'b1;
        ocyc_nxt = prod_r[30:20];
        oon_nxt = ton_r;
        opsc_nxt = psc_r;
      end
      default: ton_nxt = ton_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_IDLE;
      ovalid_r <= 1'b0;
      integ_r <= 17'd0;
      gain_r <= GAIN_RESET;
      duty_r <= DUTY_RESET;
    end else begin
      step_r <= step_nxt;
      ovalid_r <= ovalid_nxt;
      integ_r <= integ_nxt;
      gain_r <= gain_nxt;
      duty_r <= duty_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tgt_r <= tgt_nxt;
    meas_r <= meas_nxt;
    mul_r <= mul_nxt;
    limit_r <= limit_nxt;
    dsat_r <= dsat_nxt;
    period_r <= period_nxt;
    prod_r <= prod_nxt;
    psc_r <= psc_nxt;
    plo_r <= plo_nxt;
    phi_r <= phi_nxt;
    ton_r <= ton_nxt;
    ocyc_r <= ocyc_nxt;
    oon_r <= oon_nxt;
    opsc_r <= opsc_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata = {6'd0, opsc_r, oon_r, ocyc_r};

endmodule

`default_nettype wire
